// File: hw/rtl/kfilt_pkg.sv
`default_nettype none

package kfilt_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 1024;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned WIDTH_W     = 11;
    localparam int unsigned HEIGHT_W    = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(256);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(256);

    // signed kernel sum, covers -2040 .. 4080
    localparam int unsigned SUM_W = 13;
    localparam int unsigned MAG_W = SUM_W - 1;

    // floor(s * 0.11111) by reciprocal, exact for every nine-pixel sum
    localparam int unsigned BOX_SHIFT = 28;
    localparam int unsigned MUL_W     = 25;
    localparam logic [MUL_W-1:0] BOX_MUL =
        MUL_W'(((64'd11111 << BOX_SHIFT) + 64'd99999) / 64'd100000);

    // floor(m / 3) for m up to 765
    localparam int unsigned THIRD_SHIFT = 11;
    localparam logic [MUL_W-1:0] THIRD_MUL = MUL_W'(683);

    localparam int unsigned GAUSS_SHIFT   = 4;
    localparam int unsigned SOBEL_SHIFT   = 2;
    localparam int unsigned LAPLACE_SHIFT = 3;

    localparam logic signed [SUM_W-1:0] SHARP_MAX = SUM_W'(255);

    typedef enum logic [MODE_W-1:0] {
        MODE_BOX       = 3'd0,
        MODE_GAUSS     = 3'd1,
        MODE_PREWITT_X = 3'd2,
        MODE_PREWITT_Y = 3'd3,
        MODE_SOBEL_X   = 3'd4,
        MODE_SOBEL_Y   = 3'd5,
        MODE_LAPLACE   = 3'd6,
        MODE_SHARPEN   = 3'd7
    } filter_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FILTER_MODE  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        filter_mode_t          mode;
        logic [WIDTH_W-1:0]    width;
        logic [HEIGHT_W-1:0]   height;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } pix_out_t;

    // one new window column plus its position flags
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] px;
        logic             has_result;
        logic             last;
    } column_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] value;
        filter_mode_t            mode;
        logic                    last;
    } raw_t;

endpackage

`default_nettype wire

// File: hw/rtl/kfilt_stream_if.sv
`default_nettype none

interface kfilt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/kernel_3x3_convolution_filter.sv
`default_nettype none

// channel    dir   payload                       accepted when
// pix_in     in    pixel_in[7:0]                 pix_in.valid && pix_in.ready
// pix_out    out   pixel_out[7:0], frame_last    pix_out.valid && pix_out.ready
// cfg        in    cfg_index, cfg_data[15:0]     cfg_we
//
// one pixel per clock sustained while pix_out is ready; each row store takes one read on accept
// and one write-back when the item moves on, on separate ports.
// a window's result is registered in turn in the row-store read, window, kernel and output registers.
// border pixels produce no output item.
// reset clears counters, config and valid flags; the row stores are not cleared.
// each stage holds while the one after it is full, so a waiting output lets input in
// only until the stages behind it have filled up.

module kernel_3x3_convolution_filter
    import kfilt_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    kfilt_stream_if.sink           pix_in,
    kfilt_stream_if.source         pix_out
);

    cfg_t    cfg_reg;
    logic    col_valid;
    logic    col_ready;
    column_t col;
    logic    raw_valid;
    logic    raw_ready;
    raw_t    raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_BOX;
            cfg_reg.width  <= WIDTH_RESET;
            cfg_reg.height <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_MODE:  cfg_reg.mode   <= filter_mode_t'(cfg_data[MODE_W-1:0]);
                REG_IMAGE_WIDTH:  cfg_reg.width  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.height <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    kfilt_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix_in    (pix_in),
        .col_valid (col_valid),
        .col_ready (col_ready),
        .col       (col)
    );

    kfilt_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (cfg_reg.mode),
        .col_valid (col_valid),
        .col_ready (col_ready),
        .col       (col),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready),
        .raw       (raw)
    );

    kfilt_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready),
        .raw       (raw),
        .pix_out   (pix_out)
    );

endmodule

`default_nettype wire

// File: hw/rtl/kfilt_line_store.sv
`default_nettype none

module kfilt_line_store
    import kfilt_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    kfilt_stream_if.sink pix_in,
    output logic         col_valid,
    input  logic         col_ready,
    output column_t      col
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
    localparam int unsigned RW = HEIGHT_W + 1;

    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [HEIGHT_W-1:0] row_reg;
    logic [HEIGHT_W-1:0] row_next;

    logic [EW-1:0]       w_cfg;
    logic [EW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [EW-1:0]       col_ext;
    logic [EW-1:0]       c_ext;
    logic [EW-1:0]       c_inc;
    logic [RW-1:0]       r_pre;
    logic [RW-1:0]       r_cur;
    logic [RW-1:0]       r_inc;
    logic                col_wrap;
    logic                has_result;
    logic                last;

    logic                in_fire;
    logic                rd_fire;
    logic                rd_valid_reg;
    logic [CW-1:0]       rd_addr;
    logic [CW-1:0]       wr_addr_reg;
    logic [PIX_W-1:0]    near_rd_reg;
    logic [PIX_W-1:0]    far_rd_reg;
    logic [PIX_W-1:0]    px_reg;
    logic                has_result_reg;
    logic                last_reg;

    logic [PIX_W-1:0]    near_mem [MAX_WIDTH];
    logic [PIX_W-1:0]    far_mem  [MAX_WIDTH];

    // position of the incoming pixel, with size clamps and wrap after a size change
    always_comb begin
        w_cfg = EW'(cfg.width);
        if (w_cfg < EW'(3))
        begin
            w_eff = EW'(3);
        end
        else if (w_cfg > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_cfg;
        end
        h_eff    = (cfg.height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : cfg.height;

        col_ext  = EW'(col_reg);
        col_wrap = (col_ext >= w_eff);
        c_ext    = col_wrap ? '0 : col_ext;
        r_pre    = RW'(row_reg) + RW'(col_wrap);
        r_cur    = (r_pre >= RW'(h_eff)) ? '0 : r_pre;

        c_inc = c_ext + EW'(1);
        r_inc = r_cur + RW'(1);
        if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= RW'(h_eff)) ? '0 : r_inc[HEIGHT_W-1:0];
        end
        else
        begin
            col_next = c_inc[CW-1:0];
            row_next = r_cur[HEIGHT_W-1:0];
        end

        rd_addr    = c_ext[CW-1:0];
        has_result = (r_cur >= RW'(2)) && (c_ext >= EW'(2));
        last       = (r_cur == RW'(h_eff) - RW'(1)) && (c_ext == w_eff - EW'(1));
    end

    assign pix_in.ready = !rd_valid_reg || col_ready;
    assign in_fire      = pix_in.valid && pix_in.ready;
    assign rd_fire      = rd_valid_reg && col_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (pix_in.ready)
            begin
                rd_valid_reg <= pix_in.valid;
            end
        end
    end

    // read on accept, write back when the item leaves this stage;
    // successive items hit different columns, so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            near_rd_reg    <= near_mem[rd_addr];
            far_rd_reg     <= far_mem[rd_addr];
            px_reg         <= pix_in.data.pixel_in;
            wr_addr_reg    <= rd_addr;
            has_result_reg <= has_result;
            last_reg       <= last;
        end
        if (rd_fire)
        begin
            near_mem[wr_addr_reg] <= px_reg;
            far_mem[wr_addr_reg]  <= near_rd_reg;
        end
    end

    assign col_valid      = rd_valid_reg;
    assign col.top        = far_rd_reg;
    assign col.mid        = near_rd_reg;
    assign col.px         = px_reg;
    assign col.has_result = has_result_reg;
    assign col.last       = last_reg;

    a_rmw_addr: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && rd_fire |-> rd_addr != wr_addr_reg)
        else $error("row store read and write hit the same column");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < MAX_WIDTH)
        else $error("column counter beyond row store depth");

    a_last_interior: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last |-> has_result)
        else $error("frame end flagged on a border pixel");

endmodule

`default_nettype wire

// File: hw/rtl/kfilt_window.sv
`default_nettype none

module kfilt_window
    import kfilt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  filter_mode_t mode,
    input  logic         col_valid,
    output logic         col_ready,
    input  column_t      col,
    output logic         raw_valid,
    input  logic         raw_ready,
    output raw_t         raw
);

    logic [PIX_W-1:0]        win_reg [9];
    logic                    win_valid_reg;
    logic                    win_last_reg;
    logic                    raw_valid_reg;
    raw_t                    raw_reg;
    raw_t                    raw_next;
    logic                    raw_in_ready;
    logic                    col_fire;
    logic                    win_adv;

    logic signed [SUM_W-1:0] p [9];
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] nb;
    logic signed [SUM_W-1:0] kern;

    assign raw_in_ready = !raw_valid_reg || raw_ready;
    assign col_ready    = !win_valid_reg || raw_in_ready;
    assign col_fire     = col_valid && col_ready;
    assign win_adv      = win_valid_reg && raw_in_ready;

    always_comb begin
        for (int i = 0; i < 9; i++)
        begin
            p[i] = $signed({{(SUM_W-PIX_W){1'b0}}, win_reg[i]});
        end
        total = p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7] + p[8];
        nb    = total - p[4];
        case (mode)
            MODE_BOX:       kern = total;
            MODE_GAUSS:     kern = p[0] + p[2] + p[6] + p[8]
                                 + ((p[1] + p[3] + p[5] + p[7]) <<< 1) + (p[4] <<< 2);
            MODE_PREWITT_X: kern = (p[2] + p[5] + p[8]) - (p[0] + p[3] + p[6]);
            MODE_PREWITT_Y: kern = (p[6] + p[7] + p[8]) - (p[0] + p[1] + p[2]);
            MODE_SOBEL_X:   kern = (p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]);
            MODE_SOBEL_Y:   kern = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
            MODE_LAPLACE:   kern = (p[4] <<< 3) - nb;
            MODE_SHARPEN:   kern = (p[4] <<< 3) + p[4] - nb;
            default:        kern = total;
        endcase
        raw_next.value = kern;
        raw_next.mode  = mode;
        raw_next.last  = win_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            raw_valid_reg <= 1'b0;
        end
        else
        begin
            // border items still shift the window but go no further
            if (col_ready)
            begin
                win_valid_reg <= col_valid && col.has_result;
            end
            if (raw_in_ready)
            begin
                raw_valid_reg <= win_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_fire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]     <= win_reg[i*3 + 1];
                win_reg[i*3 + 1] <= win_reg[i*3 + 2];
            end
            win_reg[2]   <= col.top;
            win_reg[5]   <= col.mid;
            win_reg[8]   <= col.px;
            win_last_reg <= col.last;
        end
        if (win_adv)
        begin
            raw_reg <= raw_next;
        end
    end

    assign raw_valid = raw_valid_reg;
    assign raw       = raw_reg;

    a_smooth_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        raw_valid_reg && (raw_reg.mode == MODE_BOX || raw_reg.mode == MODE_GAUSS)
        |-> !raw_reg.value[SUM_W-1])
        else $error("smoothing kernel sum went negative");

endmodule

`default_nettype wire

// File: hw/rtl/kfilt_scale.sv
`default_nettype none

module kfilt_scale
    import kfilt_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           raw_valid,
    output logic           raw_ready,
    input  raw_t           raw,
    kfilt_stream_if.source pix_out
);

    localparam int unsigned PROD_W = MAG_W + MUL_W;

    logic [MAG_W-1:0]  mag;
    logic [MUL_W-1:0]  mul_k;
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  result;
    logic              out_valid_reg;
    pix_out_t          out_reg;

    always_comb begin
        mag   = raw.value[SUM_W-1] ? MAG_W'(-raw.value) : MAG_W'(raw.value);
        mul_k = (raw.mode == MODE_BOX) ? BOX_MUL : THIRD_MUL;
        prod  = PROD_W'(mag) * PROD_W'(mul_k);
        case (raw.mode) inside
            MODE_BOX:
                result = prod[BOX_SHIFT +: PIX_W];
            MODE_GAUSS:
                result = mag[GAUSS_SHIFT +: PIX_W];
            MODE_PREWITT_X, MODE_PREWITT_Y:
                result = prod[THIRD_SHIFT +: PIX_W];
            MODE_SOBEL_X, MODE_SOBEL_Y:
                result = mag[SOBEL_SHIFT +: PIX_W];
            MODE_LAPLACE:
                result = mag[LAPLACE_SHIFT +: PIX_W];
            MODE_SHARPEN:
            begin
                if (raw.value[SUM_W-1])
                begin
                    result = '0;
                end
                else if (raw.value > SHARP_MAX)
                begin
                    result = '1;
                end
                else
                begin
                    result = raw.value[PIX_W-1:0];
                end
            end
            default:
                result = '0;
        endcase
    end

    assign raw_ready = !out_valid_reg || pix_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (raw_ready)
        begin
            out_valid_reg <= raw_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw_valid && raw_ready)
        begin
            out_reg.pixel_out  <= result;
            out_reg.frame_last <= raw.last;
        end
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.data  = out_reg;

endmodule

`default_nettype wire

// File: verif/filter_result_checker.sv
`timescale 1ns / 100ps

module filter_result_checker
    import kfilt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pix_in_valid,
    input  logic                   pix_in_ready,
    input  pix_in_t                pix_in_data,
    input  logic                   pix_out_valid,
    input  logic                   pix_out_ready,
    input  pix_out_t               pix_out_data,
    output int unsigned            fail_count,
    output int unsigned            pending
);

    logic [PIX_W-1:0]    line_near [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]    line_far [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]    win [9];
    int unsigned         col;
    int unsigned         row;
    filter_mode_t        mode;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    pix_out_t            expected_pixels [$];
    pix_out_t            want;
    int unsigned         fails;

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [PIX_W-1:0] convolve_window(filter_mode_t m,
                                                         logic [PIX_W-1:0] w [9]);
        int p [9];
        int total;
        int ring;
        int acc;
        total = 0;
        for (int i = 0; i < 9; i++)
        begin
            p[i] = int'(w[i]);
            total += p[i];
        end
        ring = total - p[4];
        case (m)
            MODE_BOX:       acc = (total * 11111) / 100000;
            MODE_GAUSS:     acc = (p[0] + 2 * p[1] + p[2] + 2 * p[3] + 4 * p[4] +
                                   2 * p[5] + p[6] + 2 * p[7] + p[8]) / 16;
            MODE_PREWITT_X: acc = magnitude((p[2] + p[5] + p[8]) - (p[0] + p[3] + p[6])) / 3;
            MODE_PREWITT_Y: acc = magnitude((p[6] + p[7] + p[8]) - (p[0] + p[1] + p[2])) / 3;
            MODE_SOBEL_X:   acc = magnitude((p[2] + 2 * p[5] + p[8]) -
                                            (p[0] + 2 * p[3] + p[6])) / 4;
            MODE_SOBEL_Y:   acc = magnitude((p[6] + 2 * p[7] + p[8]) -
                                            (p[0] + 2 * p[1] + p[2])) / 4;
            MODE_LAPLACE:   acc = magnitude(8 * p[4] - ring) / 8;
            default:
            begin
                acc = 9 * p[4] - ring;
                if (acc < 0)
                    acc = 0;
                else if (acc > 255)
                    acc = 255;
            end
        endcase
        return acc[PIX_W-1:0];
    endfunction

    task automatic shift_in_pixel(logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        pix_out_t         res;
        w = (width < 3) ? 3 : ((width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width);
        h = (height < 3) ? 3 : height;
        // counters may sit past a size that was narrowed since the last pixel
        if (col >= w)
        begin
            col = 0;
            row++;
        end
        if (row >= h)
            row = 0;
        c = col;
        r = row;
        top = line_far[c];
        mid = line_near[c];
        line_far[c] = mid;
        line_near[c] = px;
        for (int i = 0; i < 3; i++)
        begin
            win[i * 3] = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        if (r >= 2 && c >= 2)
        begin
            res.pixel_out = convolve_window(mode, win);
            res.frame_last = (r == h - 1) && (c == w - 1);
            expected_pixels.push_back(res);
        end
        col = c + 1;
        if (col >= w)
        begin
            col = 0;
            row = r + 1;
            if (row >= h)
                row = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (win[i])
                win[i] = '0;
            col = 0;
            row = 0;
            mode = MODE_BOX;
            width = WIDTH_RESET;
            height = HEIGHT_RESET;
            expected_pixels.delete();
            fails = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FILTER_MODE:  mode = filter_mode_t'(cfg_data[MODE_W-1:0]);
                    REG_IMAGE_WIDTH:  width = cfg_data[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: height = cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (pix_in_valid && pix_in_ready)
                shift_in_pixel(pix_in_data.pixel_in);
            if (pix_out_valid && pix_out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual pixel_out %0d frame_last %0d",
                             $time, pix_out_data.pixel_out, pix_out_data.frame_last);
                    fails++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pix_out_data.pixel_out !== want.pixel_out)
                    begin
                        $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                                 $time, want.pixel_out, pix_out_data.pixel_out);
                        fails++;
                    end
                    if (pix_out_data.frame_last !== want.frame_last)
                    begin
                        $display("%0t: frame_last mismatch, expected %0d, actual %0d",
                                 $time, want.frame_last, pix_out_data.frame_last);
                        fails++;
                    end
                end
            end
            fail_count <= fails;
            pending <= expected_pixels.size();
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import kfilt_pkg::*;

    typedef enum int unsigned {
        STYLE_NOISE,
        STYLE_EXTREMES,
        STYLE_FLAT,
        STYLE_RAMP
    } pixel_style_t;

    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned RUN_CAP      = 120;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int unsigned            fail_count;
    int unsigned            pending;

    // stimulus side view of the image size and raster position
    logic [WIDTH_W-1:0]     width_reg = WIDTH_RESET;
    logic [HEIGHT_W-1:0]    height_reg = HEIGHT_RESET;
    int unsigned            at_col = 0;
    int unsigned            at_row = 0;
    int unsigned            burst_left = 0;
    bit                     gaps_on = 1'b1;

    kfilt_stream_if #(.T(pix_in_t))  pix_in ();
    kfilt_stream_if #(.T(pix_out_t)) pix_out ();

    kernel_3x3_convolution_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    filter_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pix_in_valid  (pix_in.valid),
        .pix_in_ready  (pix_in.ready),
        .pix_in_data   (pix_in.data),
        .pix_out_valid (pix_out.valid),
        .pix_out_ready (pix_out.ready),
        .pix_out_data  (pix_out.data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned eff_width();
        if (width_reg < 3)
            return 3;
        if (width_reg > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg < 3) ? 3 : height_reg;
    endfunction

    // pixels left in the current frame, counting the lazy wrap after a narrowing
    function automatic int unsigned frame_left();
        int unsigned c;
        int unsigned r;
        c = at_col;
        r = at_row;
        if (c >= eff_width())
        begin
            c = 0;
            r++;
        end
        if (r >= eff_height())
            r = 0;
        return eff_width() * eff_height() - (r * eff_width() + c);
    endfunction

    function automatic bit at_frame_start();
        return frame_left() == eff_width() * eff_height();
    endfunction

    function automatic logic [PIX_W-1:0] make_pixel(pixel_style_t style, int unsigned idx);
        case (style)
            STYLE_NOISE:    return PIX_W'($urandom_range(0, 255));
            STYLE_EXTREMES: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            STYLE_FLAT:     return PIX_W'(120 + $urandom_range(0, 15));
            default:        return PIX_W'(idx * 7);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pattern_pixel(int unsigned k, int unsigned c);
        case (k % 4)
            0:       return (c == 1) ? 8'h00 : 8'hff;
            1:       return (c == 1) ? 8'hff : 8'h00;
            2:       return 8'hff;
            default: return 8'h00;
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg = WIDTH_W'(value);
            REG_IMAGE_HEIGHT: height_reg = HEIGHT_W'(value);
            default: ;
        endcase
    endtask

    task automatic push_pixel(logic [PIX_W-1:0] px);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap != 0)
            begin
                pix_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix_in.valid <= 1'b1;
        pix_in.data.pixel_in <= px;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        if (at_col >= eff_width())
        begin
            at_col = 0;
            at_row++;
        end
        if (at_row >= eff_height())
            at_row = 0;
        at_col++;
        if (at_col >= eff_width())
        begin
            at_col = 0;
            at_row++;
            if (at_row >= eff_height())
                at_row = 0;
        end
    endtask

    task automatic send_run(int unsigned count, pixel_style_t style);
        for (int unsigned k = 0; k < count; k++)
            push_pixel(make_pixel(style, k));
        pix_in.valid <= 1'b0;
    endtask

    // sender holds off until every predicted item is out and the pipe is empty
    task automatic settle();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int unsigned  stretch;
        int unsigned  pattern;
        int unsigned  tick;
        pix_out.ready = 1'b0;
        tick = 0;
        forever
        begin
            stretch = $urandom_range(16, 300);
            pattern = $urandom_range(0, 3);
            repeat (stretch)
            begin
                @(posedge clk);
                tick++;
                case (pattern)
                    0:       pix_out.ready <= 1'b1;
                    1:       pix_out.ready <= ($urandom_range(0, 1) != 0);
                    2:       pix_out.ready <= ($urandom_range(0, 3) == 0);
                    default: pix_out.ready <= ((tick % 8) < 5);
                endcase
            end
        end
    end

    initial
    begin
        filter_mode_t  m;
        pixel_style_t  style;
        int unsigned   phase;
        int unsigned   count;
        int unsigned   left;
        int unsigned   value;
        int unsigned   random_sent;
        bit            wide_done;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FILTER_MODE;
        cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // narrow tall strip: one row per kernel, width below the minimum
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 65535);
        m = m.first();
        for (int unsigned k = 0; k < 10; k++)
        begin
            if (k >= 2)
            begin
                pix_in.valid <= 1'b0;
                settle();
                write_reg(REG_FILTER_MODE, m);
                m = m.next();
            end
            for (int unsigned c = 0; c < 3; c++)
                push_pixel(pattern_pixel(k, c));
        end
        pix_in.valid <= 1'b0;
        settle();
        // shrinking the height below the current row restarts the frame
        write_reg(REG_IMAGE_HEIGHT, 0);

        phase = 0;
        random_sent = 0;
        wide_done = 1'b0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            phase++;
            gaps_on = ($urandom_range(0, 3) != 0);
            style = pixel_style_t'($urandom_range(0, 3));
            write_reg(REG_FILTER_MODE, $urandom_range(0, 7));
            if (!wide_done && phase >= 4 && at_frame_start())
            begin
                // widest frame, once: width past the maximum acts as the maximum,
                // then a narrowing mid-row wraps the counters to the next row
                write_reg(REG_IMAGE_WIDTH, 2047);
                write_reg(REG_IMAGE_HEIGHT, 3);
                wide_done = 1'b1;
                send_run(RUN_CAP, style);
                random_sent += RUN_CAP;
                settle();
                write_reg(REG_IMAGE_WIDTH, $urandom_range(3, 12));
                continue;
            end
            if (at_frame_start())
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 7))
                        0:       value = $urandom_range(0, 2);
                        1:       value = $urandom_range(13, 40);
                        default: value = $urandom_range(3, 12);
                    endcase
                    write_reg(REG_IMAGE_WIDTH, value);
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 7))
                        0:       value = $urandom_range(0, 2);
                        1:       value = $urandom_range(200, 65535);
                        default: value = $urandom_range(3, 8);
                    endcase
                    write_reg(REG_IMAGE_HEIGHT, value);
                end
            end
            else
            begin
                // mid-frame the width may only shrink, so no unwritten column is read
                if ($urandom_range(0, 2) == 0)
                    write_reg(REG_IMAGE_WIDTH, $urandom_range(3, eff_width()));
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 10));
            end
            left = frame_left();
            if (left > RUN_CAP || $urandom_range(0, 3) == 0)
                count = $urandom_range(1, (left > RUN_CAP) ? RUN_CAP : left);
            else
                count = left;
            send_run(count, style);
            random_sent += count;
        end

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
